FILE: sv/wsr_pkg.sv
`default_nettype none
package wsr_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_EASY_WEIGHT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_WEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HARD_WEIGHT   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCORE_CAP     = 2'd3;

  // Register reset values
  localparam logic [5:0]  EASY_WEIGHT_RST   = 6'd10;
  localparam logic [5:0]  MEDIUM_WEIGHT_RST = 6'd20;
  localparam logic [5:0]  HARD_WEIGHT_RST   = 6'd30;
  localparam logic [15:0] SCORE_CAP_RST     = 16'd100;

  // Width of one stored record: id, score, time
  localparam int unsigned ENTRY_W = 56;

  typedef struct packed {
    logic [23:0] student_id;
    logic [7:0]  easy_a;
    logic [7:0]  easy_b;
    logic [7:0]  easy_c;
    logic [7:0]  medium_a;
    logic [7:0]  medium_b;
    logic [7:0]  medium_c;
    logic [7:0]  hard_a;
    logic [7:0]  hard_b;
    logic [7:0]  hard_c;
    logic [15:0] solve_time;
    logic        last_record;
  } item_t;

  typedef struct packed {
    logic [23:0] ranked_id;
    logic [15:0] ranked_score;
    logic [15:0] ranked_time;
    logic        last_result;
  } rank_t;

  typedef struct packed {
    logic [5:0]  easy_weight;
    logic [5:0]  medium_weight;
    logic [5:0]  hard_weight;
    logic [15:0] score_cap;
  } cfg_t;

  typedef struct packed {
    logic [23:0] id;
    logic [15:0] score;
    logic [15:0] time_val;
  } entry_t;

  // One classified request on its way to the back end
  typedef struct packed {
    entry_t entry;
    logic   last;
  } qitem_t;

endpackage
`default_nettype wire

FILE: sv/wsr_ram.sv
`default_nettype none
module wsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/wsr_front.sv
`default_nettype none
module wsr_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire wsr_pkg::cfg_t  cfg,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire wsr_pkg::item_t item,
  output logic                q_valid,
  input  wire logic           q_ready,
  output wsr_pkg::qitem_t     q_data
);

  // Stage A: group sums
  logic        a_valid;
  logic [9:0]  a_easy_sum;
  logic [9:0]  a_med_sum;
  logic [9:0]  a_hard_sum;
  logic [23:0] a_id;
  logic [15:0] a_time;
  logic        a_last;

  // Stage B: weighted products
  logic        b_valid;
  logic [15:0] b_easy_prod;
  logic [15:0] b_med_prod;
  logic [15:0] b_hard_prod;
  logic [23:0] b_id;
  logic [15:0] b_time;
  logic        b_last;

  logic        b_en;
  logic        a_en;
  logic [17:0] total;
  logic [15:0] score;

  assign b_en       = !b_valid || q_ready;
  assign a_en       = !a_valid || b_en;
  assign item_ready = a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= item_valid;
    end
    if (a_en) begin
      a_easy_sum <= 10'(item.easy_a) + 10'(item.easy_b) + 10'(item.easy_c);
      a_med_sum  <= 10'(item.medium_a) + 10'(item.medium_b) + 10'(item.medium_c);
      a_hard_sum <= 10'(item.hard_a) + 10'(item.hard_b) + 10'(item.hard_c);
      a_id       <= item.student_id;
      a_time     <= item.solve_time;
      a_last     <= item.last_record;
    end
  end

  // Each product fits in 16 bits: 765 * 63 at most
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_en) begin
      b_valid <= a_valid;
    end
    if (b_en) begin
      b_easy_prod <= 16'(a_easy_sum) * 16'(cfg.easy_weight);
      b_med_prod  <= 16'(a_med_sum) * 16'(cfg.medium_weight);
      b_hard_prod <= 16'(a_hard_sum) * 16'(cfg.hard_weight);
      b_id        <= a_id;
      b_time      <= a_time;
      b_last      <= a_last;
    end
  end

  // Sum and clamp to the cap
  assign total = 18'(b_easy_prod) + 18'(b_med_prod) + 18'(b_hard_prod);
  assign score = (total > 18'(cfg.score_cap)) ? cfg.score_cap : total[15:0];

  assign q_valid               = b_valid;
  assign q_data.entry.id       = b_id;
  assign q_data.entry.score    = score;
  assign q_data.entry.time_val = b_time;
  assign q_data.last           = b_last;

endmodule
`default_nettype wire

FILE: sv/wsr_fifo.sv
`default_nettype none
module wsr_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire wsr_pkg::qitem_t wr_data,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output wsr_pkg::qitem_t      rd_data
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  wsr_pkg::qitem_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;
  logic            push;
  logic            pop;

  assign wr_ready = (fill != CW'(DEPTH));
  assign rd_valid = (fill != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: sv/wsr_back.sv
`default_nettype none
module wsr_back #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire wsr_pkg::qitem_t q_data,
  output logic                 rank_valid,
  input  wire logic            rank_ready,
  output wsr_pkg::rank_t       rank
);

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_RD_CUR = 3'd1;
  localparam logic [2:0] ST_CUR    = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]      state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   i, i_next;
  logic [CW-1:0]   j, j_next;
  wsr_pkg::entry_t cur, cur_next;
  logic            rank_valid_next;
  wsr_pkg::rank_t  rank_next;

  logic [CW-1:0]   i_inc;
  logic [CW-1:0]   j_inc;
  logic            we;
  logic [AW-1:0]   waddr;
  wsr_pkg::entry_t wdata;
  logic [AW-1:0]   raddr;
  logic [wsr_pkg::ENTRY_W-1:0] rdata_raw;
  wsr_pkg::entry_t rdata;
  logic            swap;

  assign i_inc = i + 1'b1;
  assign j_inc = j + 1'b1;
  assign rdata = wsr_pkg::entry_t'(rdata_raw);

  // Later entry wins on higher score, or equal score and lower time
  assign swap = (cur.score < rdata.score) ||
                ((cur.score == rdata.score) && (cur.time_val > rdata.time_val));

  wsr_ram #(
    .WIDTH (wsr_pkg::ENTRY_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  // Load, exchange sort and emit sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    i_next          = i;
    j_next          = j;
    cur_next        = cur;
    rank_valid_next = rank_valid && !rank_ready;
    rank_next       = rank;
    q_ready         = 1'b0;
    we              = 1'b0;
    waddr           = count[AW-1:0];
    wdata           = q_data.entry;
    raddr           = i[AW-1:0];
    case (state)
      ST_LOAD: begin
        q_ready = 1'b1;
        if (q_valid) begin
          // records past capacity are dropped
          if (count < CW'(MAX_RECORDS)) begin
            we         = 1'b1;
            count_next = count + 1'b1;
          end
          if (q_data.last) begin
            i_next     = '0;
            state_next = ST_RD_CUR;
          end
        end
      end
      ST_RD_CUR: begin
        raddr      = i[AW-1:0];
        state_next = ST_CUR;
      end
      ST_CUR: begin
        cur_next = rdata;
        j_next   = i_inc;
        if (i_inc < count) begin
          raddr      = i_inc[AW-1:0];
          state_next = ST_SCAN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (swap) begin
          we       = 1'b1;
          waddr    = j[AW-1:0];
          wdata    = cur;
          cur_next = rdata;
        end
        if (j_inc < count) begin
          raddr      = j_inc[AW-1:0];
          j_next     = j_inc;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // position i is final once its scan is done
        if (!rank_valid || rank_ready) begin
          rank_valid_next        = 1'b1;
          rank_next.ranked_id    = cur.id;
          rank_next.ranked_score = cur.score;
          rank_next.ranked_time  = cur.time_val;
          rank_next.last_result  = (i_inc == count);
          if (i_inc == count) begin
            count_next = '0;
            state_next = ST_LOAD;
          end else begin
            i_next     = i_inc;
            state_next = ST_RD_CUR;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      rank_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      rank_valid <= rank_valid_next;
    end
    i    <= i_next;
    j    <= j_next;
    cur  <= cur_next;
    rank <= rank_next;
  end

endmodule
`default_nettype wire

FILE: sv/weighted_score_rank_sorter.sv
// Channel   Handshake                 Payload
// item      item_valid / item_ready   item (wsr_pkg::item_t)
// rank      rank_valid / rank_ready   rank (wsr_pkg::rank_t)
// config    cfg_we                    cfg_index, cfg_data
//
// Requests are scored in a two-stage front end and queued; the back end stores
// one per cycle while it is loading, so a set loads at one request per cycle.
// On the last request of a set of n records the back end sorts it in its one
// store RAM, with one result per row.
// A stalled rank channel holds the sort; the queue then fills and item_ready
// drops. Reset empties the set and restores the register defaults.
`default_nettype none
module weighted_score_rank_sorter #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_ready,
  input  wire wsr_pkg::item_t                      item,
  output logic                                     rank_valid,
  input  wire logic                                rank_ready,
  output wsr_pkg::rank_t                           rank,
  input  wire logic                                cfg_we,
  input  wire logic [wsr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [wsr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  wsr_pkg::cfg_t   cfg;
  logic            fq_valid;
  logic            fq_ready;
  wsr_pkg::qitem_t fq_data;
  logic            bq_valid;
  logic            bq_ready;
  wsr_pkg::qitem_t bq_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.easy_weight   <= wsr_pkg::EASY_WEIGHT_RST;
      cfg.medium_weight <= wsr_pkg::MEDIUM_WEIGHT_RST;
      cfg.hard_weight   <= wsr_pkg::HARD_WEIGHT_RST;
      cfg.score_cap     <= wsr_pkg::SCORE_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wsr_pkg::REG_EASY_WEIGHT:   cfg.easy_weight   <= cfg_data[5:0];
        wsr_pkg::REG_MEDIUM_WEIGHT: cfg.medium_weight <= cfg_data[5:0];
        wsr_pkg::REG_HARD_WEIGHT:   cfg.hard_weight   <= cfg_data[5:0];
        wsr_pkg::REG_SCORE_CAP:     cfg.score_cap     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_data     (fq_data)
  );

  wsr_fifo #(
    .DEPTH (4)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_data  (bq_data)
  );

  wsr_back #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (bq_valid),
    .q_ready    (bq_ready),
    .q_data     (bq_data),
    .rank_valid (rank_valid),
    .rank_ready (rank_ready),
    .rank       (rank)
  );

endmodule
`default_nettype wire

FILE: tb/sv/tb_weighted_score_rank_sorter.sv
`default_nettype none
module tb_weighted_score_rank_sorter;
  import wsr_pkg::*;

  localparam int unsigned MAX_RECORDS   = 64;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD     = 400;

  typedef enum bit {ROW_CFG, ROW_REQ} plan_kind_e;

  // One line of the directed plan: a register setting or a request
  typedef struct packed {
    plan_kind_e kind;
    cfg_t       cfg;
    item_t      it;
    bit         typed;
    rank_t      want;
  } plan_row_t;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  item_t                  item       = '0;
  logic                   rank_valid;
  logic                   rank_ready = 1'b0;
  rank_t                  rank;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = REG_EASY_WEIGHT;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // Predictor state
  cfg_t        cur_cfg;
  entry_t      roster [MAX_RECORDS];
  int unsigned roster_len = 0;
  rank_t       ranks_due[$];

  plan_row_t   plan[$];
  rank_t       due;
  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned reqs_sent     = 0;
  int unsigned sets_sent     = 0;
  int unsigned ranks_seen    = 0;
  int unsigned cfg_writes    = 0;
  int unsigned rank_errors   = 0;

  weighted_score_rank_sorter #(.MAX_RECORDS(MAX_RECORDS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .rank_valid (rank_valid),
    .rank_ready (rank_ready),
    .rank       (rank),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("watchdog expired after %0d requests, %0d results", reqs_sent, ranks_seen);
    $display("tb_weighted_score_rank_sorter: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] weighted_score(item_t it);
    int unsigned es, ms, hs, s;
    es = 32'(it.easy_a) + 32'(it.easy_b) + 32'(it.easy_c);
    ms = 32'(it.medium_a) + 32'(it.medium_b) + 32'(it.medium_c);
    hs = 32'(it.hard_a) + 32'(it.hard_b) + 32'(it.hard_c);
    s  = es * 32'(cur_cfg.easy_weight) + ms * 32'(cur_cfg.medium_weight)
       + hs * 32'(cur_cfg.hard_weight);
    if (s > 32'(cur_cfg.score_cap)) s = 32'(cur_cfg.score_cap);
    return s[15:0];
  endfunction

  // Exchange sort: higher score first, lower time wins a score tie
  function automatic void order_roster();
    int unsigned i, j;
    entry_t t;
    for (i = 0; i < roster_len; i++) begin
      for (j = i; j < roster_len; j++) begin
        if (roster[i].score < roster[j].score ||
            (roster[i].score == roster[j].score &&
             roster[i].time_val > roster[j].time_val)) begin
          t = roster[i];
          roster[i] = roster[j];
          roster[j] = t;
        end
      end
    end
  endfunction

  function automatic void score_and_rank(item_t it);
    int unsigned k;
    rank_t r;
    // a full store drops the request, but a last flag still closes the set
    if (roster_len < MAX_RECORDS) begin
      roster[roster_len].id       = it.student_id;
      roster[roster_len].score    = weighted_score(it);
      roster[roster_len].time_val = it.solve_time;
      roster_len++;
    end
    if (it.last_record) begin
      order_roster();
      for (k = 0; k < roster_len; k++) begin
        r.ranked_id    = roster[k].id;
        r.ranked_score = roster[k].score;
        r.ranked_time  = roster[k].time_val;
        r.last_result  = (k + 1 == roster_len);
        ranks_due.push_back(r);
      end
      roster_len = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Plan building and random requests
  // ---------------------------------------------------------------------------
  function automatic item_t mk_req(logic [23:0] id, logic [7:0] ea, logic [7:0] eb,
                                   logic [7:0] ec, logic [7:0] ma, logic [7:0] mb,
                                   logic [7:0] mc, logic [7:0] ha, logic [7:0] hb,
                                   logic [7:0] hc, logic [15:0] tm, logic lst);
    item_t it;
    it.student_id  = id;
    it.easy_a      = ea;
    it.easy_b      = eb;
    it.easy_c      = ec;
    it.medium_a    = ma;
    it.medium_b    = mb;
    it.medium_c    = mc;
    it.hard_a      = ha;
    it.hard_b      = hb;
    it.hard_c      = hc;
    it.solve_time  = tm;
    it.last_record = lst;
    return it;
  endfunction

  function automatic void plan_cfg(logic [5:0] ew, logic [5:0] mw, logic [5:0] hw,
                                   logic [15:0] cap);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg.easy_weight   = ew;
    r.cfg.medium_weight = mw;
    r.cfg.hard_weight   = hw;
    r.cfg.score_cap     = cap;
    plan.push_back(r);
  endfunction

  function automatic void plan_req(item_t it);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.it   = it;
    plan.push_back(r);
  endfunction

  // single-record set: the one result is the request itself with this score
  function automatic void plan_known(item_t it, logic [15:0] score);
    plan_row_t r;
    r = '0;
    r.kind  = ROW_REQ;
    r.it    = it;
    r.typed = 1'b1;
    r.want  = {it.student_id, score, it.solve_time, 1'b1};
    plan.push_back(r);
  endfunction

  // narrow requests use tiny marks and times so that ties are common
  function automatic item_t rand_request(bit narrow, bit lst);
    item_t it;
    it.student_id = 24'($urandom);
    if (narrow) begin
      it.easy_a   = 8'($urandom_range(3));
      it.easy_b   = 8'($urandom_range(3));
      it.easy_c   = 8'($urandom_range(3));
      it.medium_a = 8'($urandom_range(3));
      it.medium_b = 8'($urandom_range(3));
      it.medium_c = 8'($urandom_range(3));
      it.hard_a   = 8'($urandom_range(3));
      it.hard_b   = 8'($urandom_range(3));
      it.hard_c   = 8'($urandom_range(3));
      it.solve_time = 16'($urandom_range(3));
    end else begin
      it.easy_a   = 8'($urandom);
      it.easy_b   = 8'($urandom);
      it.easy_c   = 8'($urandom);
      it.medium_a = 8'($urandom);
      it.medium_b = 8'($urandom);
      it.medium_c = 8'($urandom);
      it.hard_a   = 8'($urandom);
      it.hard_b   = 8'($urandom);
      it.hard_c   = 8'($urandom);
      it.solve_time = 16'($urandom);
    end
    it.last_record = lst;
    return it;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.easy_weight   = 6'($urandom);
    c.medium_weight = 6'($urandom);
    c.hard_weight   = 6'($urandom);
    case ($urandom_range(3))
      0: c.score_cap = 16'hFFFF;
      1: c.score_cap = 16'($urandom_range(300));
      default: c.score_cap = 16'($urandom);
    endcase
    return c;
  endfunction

  function automatic int idle_pick();
    case ($urandom_range(2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic send_request(item_t it, bit typed, rank_t want);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    reqs_sent++;
    if (typed) ranks_due.push_back(want);
    else score_and_rank(it);
    if (it.last_record) sets_sent++;
  endtask

  task automatic run_set(int unsigned n, bit narrow);
    int unsigned i;
    for (i = 0; i < n; i++) send_request(rand_request(narrow, i + 1 == n), 1'b0, '0);
  endtask

  // stop offering, wait for every pending result, let the pipeline empty
  task automatic settle_block();
    item_valid <= 1'b0;
    while (ranks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // high bits of the weight writes carry junk that the block must ignore
  task automatic write_regs(cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EASY_WEIGHT;
    cfg_data  <= {10'($urandom), c.easy_weight};
    @(posedge clk);
    cfg_index <= REG_MEDIUM_WEIGHT;
    cfg_data  <= {10'($urandom), c.medium_weight};
    @(posedge clk);
    cfg_index <= REG_HARD_WEIGHT;
    cfg_data  <= {10'($urandom), c.hard_weight};
    @(posedge clk);
    cfg_index <= REG_SCORE_CAP;
    cfg_data  <= c.score_cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_cfg = c;
    cfg_writes++;
  endtask

  initial begin : request_source
    int unsigned set_no;
    int unsigned spins;
    int unsigned sz;

    cur_cfg.easy_weight   = EASY_WEIGHT_RST;
    cur_cfg.medium_weight = MEDIUM_WEIGHT_RST;
    cur_cfg.hard_weight   = HARD_WEIGHT_RST;
    cur_cfg.score_cap     = SCORE_CAP_RST;

    // Directed plan, reset register values first
    plan_known(mk_req(24'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0, 1), 16'd0);
    plan_known(mk_req(24'hFFFFFF, 255, 255, 255, 255, 255, 255, 255, 255, 255,
                      16'hFFFF, 1), 16'd100);
    plan_known(mk_req(24'h1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 16'd5, 1), 16'd10);
    plan_known(mk_req(24'h2, 0, 0, 0, 0, 0, 1, 0, 1, 0, 16'd7, 1), 16'd50);
    // full ties and equal scores with differing times
    plan_req(mk_req(24'h10, 0, 2, 0, 0, 0, 0, 0, 0, 0, 16'd100, 0));
    plan_req(mk_req(24'h11, 0, 0, 2, 0, 0, 0, 0, 0, 0, 16'd100, 0));
    plan_req(mk_req(24'h12, 0, 0, 0, 1, 0, 0, 0, 0, 0, 16'd100, 0));
    plan_req(mk_req(24'h13, 0, 0, 0, 0, 0, 0, 1, 0, 0, 16'd50, 0));
    plan_req(mk_req(24'h14, 2, 0, 0, 0, 0, 0, 0, 0, 0, 16'd40, 1));
    // several clamped scores, ordered by time alone, and one zero score
    plan_req(mk_req(24'h20, 0, 0, 0, 0, 0, 0, 0, 0, 255, 16'd9, 0));
    plan_req(mk_req(24'h21, 0, 0, 0, 0, 255, 0, 0, 0, 0, 16'd3, 0));
    plan_req(mk_req(24'h22, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0, 0));
    plan_req(mk_req(24'h23, 0, 0, 255, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1));
    // largest weights, widest cap
    plan_cfg(6'd63, 6'd63, 6'd63, 16'hFFFF);
    plan_known(mk_req(24'hABCDEF, 255, 255, 255, 255, 255, 255, 255, 255, 255,
                      16'h1234, 1), 16'hFFFF);
    plan_known(mk_req(24'h30, 0, 0, 0, 0, 0, 0, 1, 0, 0, 16'd1, 1), 16'd63);
    plan_req(mk_req(24'h31, 255, 255, 255, 0, 0, 0, 0, 0, 0, 16'd2, 0));
    plan_req(mk_req(24'h32, 0, 0, 0, 255, 255, 255, 0, 0, 0, 16'd2, 0));
    plan_req(mk_req(24'h33, 0, 0, 0, 0, 0, 0, 255, 255, 0, 16'd0, 1));
    // zero weights and zero cap
    plan_cfg(6'd0, 6'd0, 6'd0, 16'd0);
    plan_known(mk_req(24'h5A5A5A, 255, 255, 255, 255, 255, 255, 255, 255, 255,
                      16'hA5A5, 1), 16'd0);
    plan_req(mk_req(24'h40, 9, 9, 9, 9, 9, 9, 9, 9, 9, 16'd8, 0));
    plan_req(mk_req(24'h41, 1, 2, 3, 4, 5, 6, 7, 8, 9, 16'd4, 1));
    // mixed weights
    plan_cfg(6'd1, 6'd63, 6'd0, 16'd40000);
    plan_req(mk_req(24'h50, 200, 100, 50, 0, 0, 0, 255, 255, 255, 16'd6, 0));
    plan_req(mk_req(24'h51, 0, 0, 0, 255, 255, 255, 0, 0, 0, 16'd6, 1));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        settle_block();
        write_regs(plan[k].cfg);
      end else begin
        send_request(plan[k].it, plan[k].typed, plan[k].want);
      end
    end

    // Random part: mostly small sets, one long stall, one store overflow
    set_no = 0;
    while (reqs_sent < 260) begin
      if (set_no % 4 == 0) begin
        settle_block();
        write_regs(rand_cfg());
        src_idle_pct  = idle_pick();
        sink_idle_pct = idle_pick();
      end
      // quiet tail, no idling on either side
      if (reqs_sent >= 205) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (set_no == 3) begin
        // hold the result side long enough for the request side to back up
        src_idle_pct = 0;
        hold_req = 1'b1;
        run_set(4, 1'b1);
        run_set(30, $urandom_range(1));
      end else if (set_no == 6) begin
        // more requests than the store holds, last flag on a dropped one
        run_set(MAX_RECORDS + 2, $urandom_range(1));
      end else begin
        sz = ($urandom_range(4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        run_set(sz, $urandom_range(2) == 0);
      end
      set_no++;
    end

    // End of run
    item_valid <= 1'b0;
    for (spins = 0; spins < 100000 && ranks_due.size() != 0; spins++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ranks_due.size() != 0) $display("%0d ranked results never arrived", ranks_due.size());
    $display("run covered %0d requests in %0d sets, %0d ranked results, %0d register settings",
             reqs_sent, sets_sent, ranks_seen, cfg_writes);
    if (rank_errors == 0 && ranks_due.size() == 0) begin
      $display("tb_weighted_score_rank_sorter: PASS");
    end else begin
      $display("tb_weighted_score_rank_sorter: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: ready pattern
  // ---------------------------------------------------------------------------
  initial begin : rank_sink
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rank_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
        rank_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      rank_ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic void flag_rank(string why, rank_t want, rank_t got);
    rank_errors++;
    if (rank_errors <= 10) begin
      $display("rank mismatch (%s) at result %0d", why, ranks_seen);
      $display("  want id=%h score=%0d time=%0d last=%b", want.ranked_id,
               want.ranked_score, want.ranked_time, want.last_result);
      $display("  got  id=%h score=%0d time=%0d last=%b", got.ranked_id,
               got.ranked_score, got.ranked_time, got.last_result);
    end
  endfunction

  // Result side: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rank_valid && rank_ready) begin
      if (ranks_due.size() == 0) begin
        flag_rank("nothing expected", '0, rank);
      end else begin
        due = ranks_due.pop_front();
        if (rank.ranked_id !== due.ranked_id ||
            rank.ranked_score !== due.ranked_score ||
            rank.ranked_time !== due.ranked_time ||
            rank.last_result !== due.last_result) begin
          flag_rank("field differs", due, rank);
        end
      end
      ranks_seen++;
    end
  end

endmodule
`default_nettype wire

FILE: filelist.f
sv/wsr_pkg.sv
sv/wsr_ram.sv
sv/wsr_front.sv
sv/wsr_fifo.sv
sv/wsr_back.sv
sv/weighted_score_rank_sorter.sv
tb/sv/tb_weighted_score_rank_sorter.sv
